[rtl/forecast_error_metrics_core_assert.svh]
// Assertion macros shared by the forecast error metrics checkers.
`ifndef FORECAST_ERROR_METRICS_CORE_ASSERT_SVH
`define FORECAST_ERROR_METRICS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("forecast error metrics check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("forecast error metrics check failed");

`endif

[rtl/fem_pkg.sv]
// Shared widths, constants and divider handshake types for the forecast error metrics block.
package fem_pkg;

    localparam int DATA_W    = 32;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int FRAC_W    = 16;
    localparam int CNT_OUT_W = 11;
    localparam int STEP_W    = $clog2(DATA_W + 1);

    // 0.1 in Q16.16, divisor used when the actual sample is zero
    localparam logic [DATA_W-1:0] TENTH_Q16 = 32'd6554;
    localparam logic [DATA_W-1:0] QUO_MAX   = '1;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] rem_init;
        logic [DATA_W-1:0] num_lo;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
    } div_rsp_t;

endpackage

[rtl/fem_sample_if.sv]
// Input channel: one (estimate, actual) pair per beat.
interface fem_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [fem_pkg::DATA_W-1:0] estimate_value;
    logic signed [fem_pkg::DATA_W-1:0] actual_value;
    logic                              last_item;

    modport source (output valid, estimate_value, actual_value, last_item, input ready);
    modport sink   (input valid, estimate_value, actual_value, last_item, output ready);
endinterface

[rtl/fem_metric_if.sv]
// Output channel: one set of run means per beat.
interface fem_metric_if;
    logic                             valid;
    logic                             ready;
    logic [fem_pkg::DATA_W-1:0]       mean_relative_error;
    logic [fem_pkg::DATA_W-1:0]       mean_absolute_error;
    logic [fem_pkg::CNT_OUT_W-1:0]    pair_count;

    modport source (output valid, mean_relative_error, mean_absolute_error, pair_count,
                    input ready);
    modport sink   (input valid, mean_relative_error, mean_absolute_error, pair_count,
                    output ready);
endinterface

[rtl/fem_serdiv.sv]
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
module fem_serdiv
(
    input  logic              clk,
    input  logic              rst_n,
    input  fem_pkg::div_req_t req,
    output fem_pkg::div_rsp_t rsp
);

    logic                         busy_reg,  busy_next;
    logic                         done_reg,  done_next;
    logic [fem_pkg::STEP_W-1:0]   step_reg,  step_next;
    logic [fem_pkg::DATA_W-1:0]   rem_reg,   rem_next;
    logic [fem_pkg::DATA_W-1:0]   num_reg,   num_next;
    logic [fem_pkg::DATA_W-1:0]   den_reg,   den_next;
    logic [fem_pkg::DATA_W-1:0]   quo_reg,   quo_next;
    logic [fem_pkg::DATA_W:0]     trial;
    logic                         fits;

    // partial remainder stays below den, so the shifted trial fits 33 bits
    assign trial = {rem_reg, num_reg[fem_pkg::DATA_W-1]} - {1'b0, den_reg};
    assign fits  = !trial[fem_pkg::DATA_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = fem_pkg::STEP_W'(fem_pkg::DATA_W);
            rem_next  = req.rem_init;
            num_next  = req.num_lo;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[fem_pkg::DATA_W-1:0]
                             : {rem_reg[fem_pkg::DATA_W-2:0], num_reg[fem_pkg::DATA_W-1]};
            num_next  = {num_reg[fem_pkg::DATA_W-2:0], 1'b0};
            quo_next  = {quo_reg[fem_pkg::DATA_W-2:0], fits};
            step_next = step_reg - fem_pkg::STEP_W'(1);
            if (step_reg == fem_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[rtl/forecast_error_metrics_core.sv]
// Top level: running mean absolute percentage error and mean absolute error.
//
// Each input beat carries one signed Q16.16 estimate/actual pair. The block
// forms d = |estimate - actual| exactly, adds it to an absolute-error sum,
// and adds floor((d << 16) / |actual|) to a relative-error sum (divisor 0.1,
// i.e. 6554, when actual is zero; quotients saturate at 0xFFFFFFFF). On the
// beat flagged last_item it emits both sums divided by the pair count as
// unsigned Q16.16, plus the count, then clears the run. Pairs beyond MAX_LEN
// in one run are dropped, but a last_item still closes the run. All
// division goes through one shared restoring divider retiring one quotient
// bit per cycle. A pair passes through accept, setup, the divider steps and
// done, or only accept and setup when the quotient is known to saturate; a
// pair dropped from a full run is only accepted. A last pair then runs the
// divider for the two means and loads the output register. One pair is
// in flight at a time; a finished result sits in the output register while
// the next pair is taken.
module forecast_error_metrics_core
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    fem_sample_if.sink   samples,
    fem_metric_if.source metrics
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = fem_pkg::DATA_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MEAN_REL,
        S_WAIT_REL,
        S_MEAN_ABS,
        S_WAIT_ABS,
        S_EMIT
    } state_t;

    state_t                        state_reg,   state_next;
    logic [fem_pkg::DIFF_W-1:0]    diff_reg,    diff_next;
    logic [fem_pkg::DATA_W-1:0]    den_reg,     den_next;
    logic                          last_reg,    last_next;
    logic [SUM_W-1:0]              rel_sum_reg, rel_sum_next;
    logic [SUM_W-1:0]              abs_sum_reg, abs_sum_next;
    logic [CNT_W-1:0]              cnt_reg,     cnt_next;
    logic [fem_pkg::DATA_W-1:0]    mr_reg,      mr_next;
    logic [fem_pkg::DATA_W-1:0]    ma_reg,      ma_next;
    logic                          ovalid_reg,  ovalid_next;
    logic [fem_pkg::DATA_W-1:0]    omr_reg,     omr_next;
    logic [fem_pkg::DATA_W-1:0]    oma_reg,     oma_next;
    logic [fem_pkg::CNT_OUT_W-1:0] ocnt_reg,    ocnt_next;

    fem_pkg::div_req_t             div_req;
    fem_pkg::div_rsp_t             div_rsp;

    logic                          accept;
    logic                          take;
    logic [fem_pkg::DIFF_W-1:0]    est_ext;
    logic [fem_pkg::DIFF_W-1:0]    act_ext;
    logic [fem_pkg::DIFF_W-1:0]    sub;
    logic [fem_pkg::DIFF_W-1:0]    diff_mag;
    logic [fem_pkg::DATA_W-1:0]    act_mag;
    logic                          quo_sat;
    logic                          acc_en;
    logic [fem_pkg::DATA_W-1:0]    acc_q;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign take          = (cnt_reg < CNT_W'(MAX_LEN));

    // exact 33-bit difference magnitude and |actual|
    assign est_ext  = {samples.estimate_value[fem_pkg::DATA_W-1], samples.estimate_value};
    assign act_ext  = {samples.actual_value[fem_pkg::DATA_W-1], samples.actual_value};
    assign sub      = est_ext - act_ext;
    assign diff_mag = sub[fem_pkg::DIFF_W-1] ? (fem_pkg::DIFF_W'(0) - sub) : sub;
    assign act_mag  = samples.actual_value[fem_pkg::DATA_W-1]
                    ? (fem_pkg::DATA_W'(0) - samples.actual_value)
                    : samples.actual_value;

    // quotient >= 2^32 exactly when floor(d / 2^16) >= den
    assign quo_sat = fem_pkg::DATA_W'(diff_reg[fem_pkg::DIFF_W-1:fem_pkg::FRAC_W]) >= den_reg;

    always_comb
    begin
        state_next   = state_reg;
        diff_next    = diff_reg;
        den_next     = den_reg;
        last_next    = last_reg;
        rel_sum_next = rel_sum_reg;
        abs_sum_next = abs_sum_reg;
        cnt_next     = cnt_reg;
        mr_next      = mr_reg;
        ma_next      = ma_reg;
        ovalid_next  = ovalid_reg;
        omr_next     = omr_reg;
        oma_next     = oma_reg;
        ocnt_next    = ocnt_reg;
        acc_en       = 1'b0;
        acc_q        = fem_pkg::QUO_MAX;
        div_req      = '0;

        if (ovalid_reg && metrics.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    diff_next = diff_mag;
                    den_next  = (act_mag == '0) ? fem_pkg::TENTH_Q16 : act_mag;
                    last_next = samples.last_item;
                    if (take)
                    begin
                        state_next = S_PREP;
                    end
                    else if (samples.last_item)
                    begin
                        state_next = S_MEAN_REL;
                    end
                end
            end
            S_PREP:
            begin
                if (quo_sat)
                begin
                    acc_en     = 1'b1;
                    state_next = last_reg ? S_MEAN_REL : S_IDLE;
                end
                else
                begin
                    // top 17 dividend bits are already below den
                    div_req.start    = 1'b1;
                    div_req.rem_init = fem_pkg::DATA_W'(
                                           diff_reg[fem_pkg::DIFF_W-1:fem_pkg::FRAC_W]);
                    div_req.num_lo   = {diff_reg[fem_pkg::FRAC_W-1:0],
                                        {fem_pkg::FRAC_W{1'b0}}};
                    div_req.den      = den_reg;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    acc_en     = 1'b1;
                    acc_q      = div_rsp.quo;
                    state_next = last_reg ? S_MEAN_REL : S_IDLE;
                end
            end
            S_MEAN_REL:
            begin
                // sum <= count * (2^32 - 1), so the high part is below the count
                div_req.start    = 1'b1;
                div_req.rem_init = fem_pkg::DATA_W'(rel_sum_reg[SUM_W-1:fem_pkg::DATA_W]);
                div_req.num_lo   = rel_sum_reg[fem_pkg::DATA_W-1:0];
                div_req.den      = fem_pkg::DATA_W'(cnt_reg);
                state_next       = S_WAIT_REL;
            end
            S_WAIT_REL:
            begin
                if (div_rsp.done)
                begin
                    mr_next    = div_rsp.quo;
                    state_next = S_MEAN_ABS;
                end
            end
            S_MEAN_ABS:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = fem_pkg::DATA_W'(abs_sum_reg[SUM_W-1:fem_pkg::DATA_W]);
                div_req.num_lo   = abs_sum_reg[fem_pkg::DATA_W-1:0];
                div_req.den      = fem_pkg::DATA_W'(cnt_reg);
                state_next       = S_WAIT_ABS;
            end
            S_WAIT_ABS:
            begin
                if (div_rsp.done)
                begin
                    ma_next    = div_rsp.quo;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || metrics.ready)
                begin
                    ovalid_next  = 1'b1;
                    omr_next     = mr_reg;
                    oma_next     = ma_reg;
                    ocnt_next    = fem_pkg::CNT_OUT_W'(cnt_reg);
                    rel_sum_next = '0;
                    abs_sum_next = '0;
                    cnt_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (acc_en)
        begin
            rel_sum_next = rel_sum_reg + SUM_W'(acc_q);
            abs_sum_next = abs_sum_reg + SUM_W'(diff_reg);
            cnt_next     = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rel_sum_reg <= '0;
            abs_sum_reg <= '0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
            diff_reg    <= '0;
            den_reg     <= '0;
            last_reg    <= 1'b0;
            mr_reg      <= '0;
            ma_reg      <= '0;
            omr_reg     <= '0;
            oma_reg     <= '0;
            ocnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rel_sum_reg <= rel_sum_next;
            abs_sum_reg <= abs_sum_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
            diff_reg    <= diff_next;
            den_reg     <= den_next;
            last_reg    <= last_next;
            mr_reg      <= mr_next;
            ma_reg      <= ma_next;
            omr_reg     <= omr_next;
            oma_reg     <= oma_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    fem_serdiv u_serdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign metrics.valid               = ovalid_reg;
    assign metrics.mean_relative_error = omr_reg;
    assign metrics.mean_absolute_error = oma_reg;
    assign metrics.pair_count          = ocnt_reg;

endmodule

[rtl/fem_checker.sv]
// Port-level checker for the forecast error metrics core, bound to the top level.
`include "forecast_error_metrics_core_assert.svh"

module fem_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fem_pkg::DATA_W-1:0]    mean_relative_error,
    input logic [fem_pkg::DATA_W-1:0]    mean_absolute_error,
    input logic [fem_pkg::CNT_OUT_W-1:0] pair_count
);

    // a result always needs at least the setup and divide cycles
    `FEM_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

    // a new result is loaded only while the input side is held off
    `FEM_ASSERT_NOW(a_result_from_busy, $rose(out_valid), !$past(in_ready))

    // stalled result beat holds
    `FEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(mean_relative_error)
                     && $stable(mean_absolute_error) && $stable(pair_count))

endmodule

bind forecast_error_metrics_core fem_checker u_fem_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (samples.valid),
    .in_ready            (samples.ready),
    .out_valid           (metrics.valid),
    .out_ready           (metrics.ready),
    .mean_relative_error (metrics.mean_relative_error),
    .mean_absolute_error (metrics.mean_absolute_error),
    .pair_count          (metrics.pair_count)
);

[sim/fem_scoreboard.sv]
// Scoreboard for the forecast error metrics core: predicts run means and checks metric beats.
`timescale 1ns / 1ps

module fem_scoreboard
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic  clk,
    input  logic  rst_n,
    fem_sample_if samples,
    fem_metric_if metrics,
    output int    mismatch_count,
    output int    means_pending
);

    typedef struct packed {
        logic [fem_pkg::DATA_W-1:0]    rel_mean;
        logic [fem_pkg::DATA_W-1:0]    abs_mean;
        logic [fem_pkg::CNT_OUT_W-1:0] count;
    } run_means_t;

    run_means_t  means_due[$];
    run_means_t  oldest_due;
    logic [41:0] rel_err_sum;
    logic [41:0] abs_err_sum;
    int unsigned run_pairs;

    initial
    begin
        mismatch_count = 0;
        means_pending  = 0;
        rel_err_sum    = '0;
        abs_err_sum    = '0;
        run_pairs      = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Fold one accepted pair into the running sums; close the run on the last pair.
    function automatic void fold_pair(input logic signed [fem_pkg::DATA_W-1:0] est,
                                      input logic signed [fem_pkg::DATA_W-1:0] act,
                                      input logic is_last);
        logic signed [fem_pkg::DATA_W+1:0] span;
        logic [fem_pkg::DIFF_W-1:0]        err_mag;
        logic [fem_pkg::DATA_W-1:0]        den;
        logic [63:0]                       ratio;
        run_means_t                        closing;
        if (run_pairs < MAX_LEN)
        begin
            span    = {{2{est[fem_pkg::DATA_W-1]}}, est} - {{2{act[fem_pkg::DATA_W-1]}}, act};
            err_mag = span[fem_pkg::DATA_W+1] ? fem_pkg::DIFF_W'(-span)
                                              : span[fem_pkg::DIFF_W-1:0];
            den     = act[fem_pkg::DATA_W-1] ? fem_pkg::DATA_W'(-act) : fem_pkg::DATA_W'(act);
            if (den == '0)
                den = fem_pkg::TENTH_Q16;
            ratio = {15'b0, err_mag, {fem_pkg::FRAC_W{1'b0}}} / {32'b0, den};
            if (ratio > {32'b0, fem_pkg::QUO_MAX})
                ratio = {32'b0, fem_pkg::QUO_MAX};
            rel_err_sum += ratio[41:0];
            abs_err_sum += 42'(err_mag);
            run_pairs++;
        end
        if (is_last)
        begin
            // a closing pair is counted unless the run is full, so run_pairs >= 1 here
            closing.rel_mean = fem_pkg::DATA_W'(rel_err_sum / 42'(run_pairs));
            closing.abs_mean = fem_pkg::DATA_W'(abs_err_sum / 42'(run_pairs));
            closing.count    = fem_pkg::CNT_OUT_W'(run_pairs);
            means_due.push_back(closing);
            rel_err_sum = '0;
            abs_err_sum = '0;
            run_pairs   = 0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // check the outgoing beat first so a same-cycle closing pair queues behind it
            if (metrics.valid && metrics.ready)
            begin
                if (means_due.size() == 0)
                    report_mismatch("metric beat with nothing pending",
                                    64'(metrics.pair_count), 64'd0);
                else
                begin
                    oldest_due = means_due.pop_front();
                    if (metrics.mean_relative_error !== oldest_due.rel_mean)
                        report_mismatch("mean_relative_error",
                                        64'(metrics.mean_relative_error),
                                        64'(oldest_due.rel_mean));
                    if (metrics.mean_absolute_error !== oldest_due.abs_mean)
                        report_mismatch("mean_absolute_error",
                                        64'(metrics.mean_absolute_error),
                                        64'(oldest_due.abs_mean));
                    if (metrics.pair_count !== oldest_due.count)
                        report_mismatch("pair_count", 64'(metrics.pair_count),
                                        64'(oldest_due.count));
                end
            end
            if (samples.valid && samples.ready)
                fold_pair(samples.estimate_value, samples.actual_value, samples.last_item);
            means_pending = means_due.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Testbench top: clock, reset, sample stimulus, metric back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int RUN_LIMIT    = 1024;    // MAX_LEN of the block under test
    localparam int CYCLE_LIMIT  = 600000;  // watchdog limit for the whole simulation
    localparam int DRAIN_CYCLES = 200;     // extra wait once no result is pending
    localparam int HOLD_CYCLES  = 3000;    // long output hold-off to back up the core
    localparam int RANDOM_ITEMS = 400;

    // receiver stall patterns, each one held for a stretch of cycles
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_BLOCKY
    } stall_mode_t;

    logic clk;
    logic rst_n;

    fem_sample_if samples_bus();
    fem_metric_if metrics_bus();

    int mismatch_count;
    int means_pending;

    int          burst_left;
    int          items_sent;
    int unsigned cycle_count;
    logic        squeeze_req;

    forecast_error_metrics_core #(
        .MAX_LEN (RUN_LIMIT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_bus),
        .metrics (metrics_bus)
    );

    fem_scoreboard #(
        .MAX_LEN (RUN_LIMIT)
    ) u_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples_bus),
        .metrics        (metrics_bus),
        .mismatch_count (mismatch_count),
        .means_pending  (means_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver side. Ready changes only at the falling edge, one update per edge.
    // The stall mode and how long it holds are re-rolled at random, so stalls land on every
    // phase of the divider loop. Once the sender asks for it, ready is held low
    // for HOLD_CYCLES so a finished result sits in the output register, the next
    // result backs up behind it, and the core has to drop samples ready.
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          phase;
        logic        squeeze_done;
        metrics_bus.ready = 1'b0;
        mode              = READY_ALWAYS;
        mode_left         = 0;
        phase             = 0;
        squeeze_done      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                metrics_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                phase++;
                case (mode)
                    READY_ALWAYS: metrics_bus.ready <= 1'b1;
                    READY_COIN:   metrics_bus.ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: metrics_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:      metrics_bus.ready <= ((phase % 16) >= 10);
                endcase
            end
        end
    end

    // One sample beat. The sender runs in bursts; between bursts valid drops
    // for a random gap, and about a third of the bursts follow with no gap so
    // back-to-back offers are covered too. Valid stays high across a burst.
    task automatic send_pair(input logic [31:0] est, input logic [31:0] act,
                             input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                samples_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        samples_bus.valid          <= 1'b1;
        samples_bus.estimate_value <= est;
        samples_bus.actual_value   <= act;
        samples_bus.last_item      <= is_last;
        burst_left--;
        items_sent++;
        do
            @(posedge clk);
        while (!samples_bus.ready);
    endtask

    // Sample values weighted toward the corners: full-range random, small
    // magnitudes of either sign, exact zero, the signed extremes and plus or minus one lsb.
    function automatic logic [31:0] pick_sample();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0, 1:
                v = $urandom();
            2:
            begin
                v = $urandom_range(0, 32'h000F_FFFF);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            3:
                v = '0;
            default:
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
        endcase
        return v;
    endfunction

    // Estimate either independent of the actual or close to it, so both big
    // and small relative errors show up.
    task automatic send_random_pair(input logic is_last);
        logic [31:0] act;
        logic [31:0] est;
        logic [31:0] nudge;
        act = pick_sample();
        if ($urandom_range(0, 2) == 0)
        begin
            nudge = $urandom_range(0, 255);
            est   = ($urandom_range(0, 1) == 1) ? act + nudge : act - nudge;
        end
        else
            est = pick_sample();
        send_pair(est, act, is_last);
    endtask

    initial
    begin
        int run_len;
        logic squeezed;
        rst_n                      = 1'b0;
        samples_bus.valid          = 1'b0;
        samples_bus.estimate_value = '0;
        samples_bus.actual_value   = '0;
        samples_bus.last_item      = 1'b0;
        squeeze_req                = 1'b0;
        burst_left                 = 0;
        items_sent                 = 0;
        squeezed                   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners.
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);  // zero actual, zero error
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);  // widest difference, 33 bits
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);  // same, other sign
        send_pair(32'h0000_0001, 32'h0000_0000, 1'b0);  // zero actual, divisor 0.1
        send_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);  // zero actual, quotient saturates
        send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);  // divisor of one lsb
        send_pair(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);  // huge over tiny, saturates
        send_pair(32'h1234_5678, 32'h1234_5678, 1'b1);  // exact match closes a run of 7
        send_pair(32'hFFFF_0000, 32'h0001_0000, 1'b1);  // -1.0 vs 1.0, error 200%
        send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);  // most negative actual
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
        send_pair(32'h0000_8000, 32'h0001_0000, 1'b0);  // half off
        send_pair(32'hFFFF_8000, 32'hFFFF_0000, 1'b0);
        send_pair(32'h0003_0000, 32'hFFFD_0000, 1'b1);

        // Random runs, mostly short. Partway through, a string of single-pair
        // runs is offered while the receiver holds off, so the core backs up.
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!squeezed && items_sent > 150)
            begin
                squeezed    = 1'b1;
                squeeze_req = 1'b1;
                repeat (30) send_random_pair(1'b1);
            end
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(1, 6);
            repeat (run_len - 1) send_random_pair(1'b0);
            send_random_pair(1'b1);
        end

        // Overlong run: pairs past the limit are dropped, the last one still closes it.
        repeat (RUN_LIMIT + 3) send_random_pair(1'b0);
        send_random_pair(1'b1);
        // and a short run right behind it to confirm the clear
        send_random_pair(1'b0);
        send_random_pair(1'b1);

        @(negedge clk);
        samples_bus.valid <= 1'b0;

        while (means_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && means_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/fem_pkg.sv
rtl/fem_sample_if.sv
rtl/fem_metric_if.sv
rtl/fem_serdiv.sv
rtl/forecast_error_metrics_core.sv
rtl/fem_checker.sv
sim/fem_scoreboard.sv
sim/tb_top.sv
